// ----- hw/rtl/mvp_pkg.sv -----
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared types and constants for the motion vector median predictor.
// ----------------------------------------------------------------------------
package mvp_pkg;

    localparam int COMP_W   = 16;
    localparam int MV_W     = 2 * COMP_W;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 144;
    localparam int OUT_W    = MV_W;

    localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ELIGIBLE = 2'd2;

    typedef logic signed [COMP_W-1:0] mvp_comp_t;

    typedef struct packed {
        logic      cur_skip;
        logic [1:0] a_status;
        logic      a_ref_zero;
        logic [MV_W-1:0] a_mv;
        logic [1:0] b_status;
        logic      b_ref_zero;
        logic [MV_W-1:0] b_mv;
        logic [1:0] c_status;
        logic [MV_W-1:0] c_mv;
        logic [1:0] d_status;
        logic [MV_W-1:0] d_mv;
    } mvp_req_t;

    // after decode: masked candidates, plus the direct (non-median) answer
    typedef struct packed {
        logic      forced;
        logic      direct;
        mvp_comp_t dir_x;
        mvp_comp_t dir_y;
        mvp_comp_t p_x;
        mvp_comp_t p_y;
        mvp_comp_t q_x;
        mvp_comp_t q_y;
        mvp_comp_t r_x;
        mvp_comp_t r_y;
    } mvp_dec_t;

    typedef struct packed {
        logic pq;
        logic rp;
        logic rq;
    } mvp_lt_t;

    typedef struct packed {
        mvp_dec_t dec;
        mvp_lt_t  lt_x;
        mvp_lt_t  lt_y;
    } mvp_cmp_t;

    typedef struct packed {
        logic      forced;
        mvp_comp_t x;
        mvp_comp_t y;
    } mvp_res_t;

    function automatic mvp_comp_t mvp_med3(input mvp_comp_t p, input mvp_comp_t q,
                                           input mvp_comp_t r, input mvp_lt_t lt);
        mvp_comp_t m;
        if (lt.pq)
        begin
            m = lt.rp ? p : (lt.rq ? r : q);
        end
        else
        begin
            m = lt.rq ? q : (lt.rp ? r : p);
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/mvp_decode.sv -----
// ----------------------------------------------------------------------------
// mvp_decode
// Stage 1: neighbor selection, eligibility masking and skip rule.
// ----------------------------------------------------------------------------
module mvp_decode
    import mvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mvp_req_t in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output mvp_dec_t out_dec
);

    logic     valid_reg;
    mvp_dec_t dec_reg;
    mvp_dec_t dec_next;

    logic            pa, pb, pc, pt;
    logic            ea, eb, et;
    logic [1:0]      t_status;
    logic [MV_W-1:0] t_mv;
    logic [MV_W-1:0] va, vb, vt, vd;
    logic            forced, multi;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

    always_comb
    begin
        pc       = in_req.c_status != ST_ABSENT;
        t_status = pc ? in_req.c_status : in_req.d_status;
        t_mv     = pc ? in_req.c_mv : in_req.d_mv;
        pa       = in_req.a_status != ST_ABSENT;
        pb       = in_req.b_status != ST_ABSENT;
        pt       = t_status != ST_ABSENT;
        ea       = in_req.a_status == ST_ELIGIBLE;
        eb       = in_req.b_status == ST_ELIGIBLE;
        et       = t_status == ST_ELIGIBLE;
        forced   = in_req.cur_skip && (!pa || !pb ||
                   (in_req.a_ref_zero && in_req.a_mv == '0) ||
                   (in_req.b_ref_zero && in_req.b_mv == '0));
        va       = ea ? in_req.a_mv : '0;
        vb       = eb ? in_req.b_mv : '0;
        vt       = et ? t_mv : '0;
        multi    = (ea && eb) || (ea && et) || (eb && et);
        // with B and T both absent only A can be eligible, so no median then
        vd       = forced ? '0 : (va | vb | vt);

        dec_next.forced = forced;
        dec_next.direct = forced || !multi || (!pb && !pt);
        dec_next.dir_x  = mvp_comp_t'(vd[COMP_W-1:0]);
        dec_next.dir_y  = mvp_comp_t'(vd[MV_W-1:COMP_W]);
        dec_next.p_x    = mvp_comp_t'(va[COMP_W-1:0]);
        dec_next.p_y    = mvp_comp_t'(va[MV_W-1:COMP_W]);
        dec_next.q_x    = mvp_comp_t'(vb[COMP_W-1:0]);
        dec_next.q_y    = mvp_comp_t'(vb[MV_W-1:COMP_W]);
        dec_next.r_x    = mvp_comp_t'(vt[COMP_W-1:0]);
        dec_next.r_y    = mvp_comp_t'(vt[MV_W-1:COMP_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dec_reg <= dec_next;
        end
    end

endmodule

// ----- hw/rtl/mvp_compare.sv -----
// ----------------------------------------------------------------------------
// mvp_compare
// Stage 2: pairwise signed compares of the three candidates, per component.
// ----------------------------------------------------------------------------
module mvp_compare
    import mvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mvp_dec_t in_dec,
    output logic     out_valid,
    input  logic     out_ready,
    output mvp_cmp_t out_cmp
);

    logic     valid_reg;
    mvp_cmp_t cmp_reg;
    mvp_cmp_t cmp_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cmp   = cmp_reg;

    always_comb
    begin
        cmp_next.dec     = in_dec;
        cmp_next.lt_x.pq = in_dec.p_x < in_dec.q_x;
        cmp_next.lt_x.rp = in_dec.r_x < in_dec.p_x;
        cmp_next.lt_x.rq = in_dec.r_x < in_dec.q_x;
        cmp_next.lt_y.pq = in_dec.p_y < in_dec.q_y;
        cmp_next.lt_y.rp = in_dec.r_y < in_dec.p_y;
        cmp_next.lt_y.rq = in_dec.r_y < in_dec.q_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmp_reg <= cmp_next;
        end
    end

endmodule

// ----- hw/rtl/mvp_select.sv -----
// ----------------------------------------------------------------------------
// mvp_select
// Stage 3: median pick or direct vector, into the output register.
// ----------------------------------------------------------------------------
module mvp_select
    import mvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mvp_cmp_t in_cmp,
    output logic     out_valid,
    input  logic     out_ready,
    output mvp_res_t out_res
);

    logic     valid_reg;
    mvp_res_t res_reg;
    mvp_res_t res_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        res_next.forced = in_cmp.dec.forced;
        if (in_cmp.dec.direct)
        begin
            res_next.x = in_cmp.dec.dir_x;
            res_next.y = in_cmp.dec.dir_y;
        end
        else
        begin
            res_next.x = mvp_med3(in_cmp.dec.p_x, in_cmp.dec.q_x, in_cmp.dec.r_x,
                                  in_cmp.lt_x);
            res_next.y = mvp_med3(in_cmp.dec.p_y, in_cmp.dec.q_y, in_cmp.dec.r_y,
                                  in_cmp.lt_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- hw/rtl/mv_median_predictor.sv -----
// ----------------------------------------------------------------------------
// mv_median_predictor
// Motion vector predictor for a 16x16 macroblock from neighbors A, B, C, D.
// ----------------------------------------------------------------------------
// Three register stages (decode, compare, select); an accepted request moves
// through them in that order, the select register driving the output, and
// one request is taken every cycle while the output side keeps up. Each stage
// holds its own valid bit, so a stall on the output only backs up as far as
// the first empty stage.
module mv_median_predictor
    import mvp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // a_status, a_ref_zero, a_mv, b_status, b_ref_zero, b_mv,
    // c_status, c_mv, d_status, d_mv, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    // cur_skip
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // pred_mv_x, pred_mv_y
    output logic [OUT_W-1:0] m_axis_tdata,
    // skip_forced_zero
    output logic             m_axis_tuser
);

    mvp_req_t req;
    mvp_dec_t dec;
    mvp_cmp_t cmp;
    mvp_res_t res;
    logic     dec_valid, dec_ready;
    logic     cmp_valid, cmp_ready;

    always_comb
    begin
        req.cur_skip   = s_axis_tuser;
        req.a_status   = s_axis_tdata[1:0];
        req.a_ref_zero = s_axis_tdata[2];
        req.a_mv       = s_axis_tdata[34:3];
        req.b_status   = s_axis_tdata[36:35];
        req.b_ref_zero = s_axis_tdata[37];
        req.b_mv       = s_axis_tdata[69:38];
        req.c_status   = s_axis_tdata[71:70];
        req.c_mv       = s_axis_tdata[103:72];
        req.d_status   = s_axis_tdata[105:104];
        req.d_mv       = s_axis_tdata[137:106];
    end

    mvp_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (req),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_dec   (dec)
    );

    mvp_compare u_compare
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_dec    (dec),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready),
        .out_cmp   (cmp)
    );

    mvp_select u_select
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmp_valid),
        .in_ready  (cmp_ready),
        .in_cmp    (cmp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.y, res.x};
    assign m_axis_tuser = res.forced;

endmodule

// ----- hw/rtl/mvp_checker.sv -----
// ----------------------------------------------------------------------------
// mvp_checker
// Port-level checks for mv_median_predictor, bound to the top level.
// ----------------------------------------------------------------------------
module mvp_checker
    import mvp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    // pipeline only refuses input when every stage, including the output, is full
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // forced skip result is always the zero vector
    a_forced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("forced skip request with nonzero vector");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output request changed while stalled");

endmodule

bind mv_median_predictor mvp_checker u_mvp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
